// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;
  localparam int KappaWidth = 24;
  localparam int TableFrac = 28;
  localparam int CordicIters = 28;
  localparam int CordicWidth = 40;
  localparam int QuotBits = 25;
  localparam logic [KappaWidth-1:0] KappaMax = 24'hFFFFFF;
  localparam logic [0:0] RegWheelBase = 1'b0;
  localparam logic [0:0] RegMinCurv = 1'b1;

  function automatic logic [TableFrac:0] atan_step(input int i);
    logic [TableFrac:0] r;
    r = '0;
    case (i)
      0: r = 29'd210828714;
      1: r = 29'd124459457;
      2: r = 29'd65760959;
      3: r = 29'd33381290;
      4: r = 29'd16755422;
      5: r = 29'd8385879;
      6: r = 29'd4193963;
      7: r = 29'd2097109;
      8: r = 29'd1048571;
      9: r = 29'd524287;
      default: r = (i <= TableFrac) ? (29'd1 << (TableFrac - i)) : '0;
    endcase
    return r;
  endfunction
endpackage

// ===== rtl/core/pps_stream_if.sv =====
interface pps_stream_if #(parameter int W = 32);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/pps_cordic.sv =====
module pps_cordic
  import pps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [CordicWidth-1:0] in_t,
  input  logic in_neg,
  input  logic in_sat,
  output logic out_valid,
  output logic [TableFrac+1:0] out_z,
  output logic out_neg,
  output logic out_sat
);
  // one micro-rotation per stage
  logic signed [CordicWidth+1:0] cx [CordicIters+1];
  logic signed [CordicWidth+1:0] cy [CordicIters+1];
  logic signed [TableFrac+2:0] cz [CordicIters+1];
  logic vld [CordicIters+1];
  logic ng [CordicIters+1];
  logic st [CordicIters+1];

  always_comb begin
    cx[0] = (CordicWidth+2)'(1) <<< TableFrac;
    cy[0] = {2'b00, in_t};
    cz[0] = '0;
    vld[0] = in_valid;
    ng[0] = in_neg;
    st[0] = in_sat;
  end

  for (genvar i = 0; i < CordicIters; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        ng[i+1] <= ng[i];
        st[i+1] <= st[i];
        if (!cy[i][CordicWidth+1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + $signed({2'b00, atan_step(i)});
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - $signed({2'b00, atan_step(i)});
        end
      end
    end
  end

  assign out_valid = vld[CordicIters];
  assign out_z = cz[CordicIters][TableFrac+2] ? '0 : cz[CordicIters][TableFrac+1:0];
  assign out_neg = ng[CordicIters];
  assign out_sat = st[CordicIters];
endmodule

// ===== rtl/core/pure_pursuit_steering_angle_unit.sv =====
// Pure pursuit steering: front, divider, product, CORDIC and output stages.
// Throughput one waypoint per cycle when not stalled; divider and CORDIC are
// fully unrolled pipelines, one quotient bit or one rotation per stage.
// Stalls freeze the whole pipeline when the output register is held.
// Synchronous reset clears valid bits and sets axle_span 689, min_curvature 0.
module pure_pursuit_steering_angle_unit
  import pps_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic clk,
  input  logic rst,
  pps_stream_if.sink   wp,
  pps_stream_if.source steer,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int CW = COORD_WIDTH;
  localparam int D2W = 2 * CW + 1;
  localparam int NW = CW + 29;
  localparam int Sh = TableFrac - ANGLE_FRAC_BITS;

  logic [11:0] axle_span;
  logic [19:0] min_curvature;
  logic en;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      axle_span <= 12'd689;
      min_curvature <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == RegWheelBase) axle_span <= pwdata[11:0];
      else min_curvature <= pwdata[19:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegWheelBase) prdata[11:0] = axle_span;
    else prdata[19:0] = min_curvature;
  end

  // stage 1: magnitudes
  logic v1, yneg1;
  logic [CW-1:0] ax1, ay1;
  logic signed [CW-1:0] xs, ys;
  assign xs = wp.data[CW-1:0];
  assign ys = wp.data[2*CW-1:CW];
  assign wp.ready = en;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= wp.valid;
    if (en) begin
      ax1 <= xs[CW-1] ? CW'(-xs) : xs;
      ay1 <= ys[CW-1] ? CW'(-ys) : ys;
      yneg1 <= ys[CW-1];
    end
  end

  // stage 2: squares
  logic v2, yneg2;
  logic [2*CW-1:0] sx2, sy2;
  logic [CW-1:0] ay2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      sx2 <= ax1 * ax1;
      sy2 <= ay1 * ay1;
      ay2 <= ay1;
      yneg2 <= yneg1;
    end
  end

  // stage 3: distance squared
  logic v3, yneg3;
  logic [D2W-1:0] d3;
  logic [CW-1:0] ay3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      d3 <= D2W'(sx2) + D2W'(sy2);
      ay3 <= ay2;
      yneg3 <= yneg2;
    end
  end

  // restoring divider, one quotient bit per stage; quotient clamps at 2^24-1
  logic [NW-1:0] rem [QuotBits+1];
  logic [QuotBits-1:0] quo [QuotBits+1];
  logic [D2W-1:0] dd [QuotBits+1];
  logic dv [QuotBits+1];
  logic dn [QuotBits+1];
  logic dz [QuotBits+1];
  logic dov [QuotBits+1];
  always_comb begin
    rem[0] = {ay3, 29'd0};
    quo[0] = '0;
    dd[0] = d3;
    dv[0] = v3;
    dn[0] = yneg3;
    dz[0] = (ay3 == '0);
    // quotient above 2^25-1 when ay*2^29 >= d*2^25, i.e. ay*16 >= d
    dov[0] = (D2W'({ay3, 4'd0}) >= d3);
  end
  for (genvar k = 0; k < QuotBits; k++) begin : g_div
    localparam int B = QuotBits - 1 - k;
    logic [NW+B:0] dsh;
    logic ge;
    assign dsh = (NW+B+1)'(dd[k]) << B;
    assign ge = ((NW+B+1)'(rem[k]) >= dsh);
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
      if (en) begin
        rem[k+1] <= ge ? NW'((NW+B+1)'(rem[k]) - dsh) : rem[k];
        quo[k+1] <= quo[k] | (ge ? (QuotBits'(1) << B) : '0);
        dd[k+1] <= dd[k];
        dn[k+1] <= dn[k];
        dz[k+1] <= dz[k];
        dov[k+1] <= dov[k];
      end
    end
  end

  // stage: clamp, floor, product with wheel base
  logic vp, pneg, psat;
  logic [CordicWidth-1:0] pmag;
  logic [KappaWidth-1:0] mag;
  logic satc, usemin;
  always_comb begin
    satc = !dz[QuotBits] && (dov[QuotBits] || quo[QuotBits][QuotBits-1]);
    mag = satc ? KappaMax : quo[QuotBits][KappaWidth-1:0];
    usemin = dz[QuotBits] || (mag < KappaWidth'(min_curvature));
    if (usemin) mag = KappaWidth'(min_curvature);
  end
  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else if (en) vp <= dv[QuotBits];
    if (en) begin
      pmag <= CordicWidth'(mag) * CordicWidth'(axle_span);
      pneg <= !usemin && dn[QuotBits];
      psat <= satc;
    end
  end

  logic cv, cneg, csat;
  logic [TableFrac+1:0] cz;
  pps_cordic u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vp), .in_t(pmag), .in_neg(pneg || pmag == '0), .in_sat(psat),
    .out_valid(cv), .out_z(cz), .out_neg(cneg), .out_sat(csat)
  );

  // output register; pneg true keeps positive sign (kappa<0 or p==0)
  logic ov;
  logic [14:0] oang;
  logic osat;
  logic [TableFrac+1:0] mang;
  assign mang = (cz + (TableFrac+2)'(1 << (Sh - 1))) >> Sh;
  assign en = !ov || steer.ready;
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en) ov <= cv;
    if (en) begin
      oang <= cneg ? mang[14:0] : 15'(-mang[14:0]);
      osat <= csat;
    end
  end
  assign steer.valid = ov;
  assign steer.data = {osat, oang};
endmodule
